// ===== src/efs_pkg.sv =====
// ----------------------------------------------------------------------------
// efs_pkg
// Shared constants and types of the 1D Euler split flux step block.
// ----------------------------------------------------------------------------
package efs_pkg;

  localparam int WORD_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 31;

  localparam logic [CFG_DATA_WIDTH-1:0] GAS_CONSTANT_RESET  = 31'd65536;
  localparam logic [CFG_DATA_WIDTH-1:0] SPECIFIC_HEAT_RESET = 31'd163840;
  localparam logic [CFG_DATA_WIDTH-1:0] HEAT_RATIO_RESET    = 31'd91750;
  localparam logic [CFG_DATA_WIDTH-1:0] STEP_RATIO_RESET    = 31'd6554;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAS_CONSTANT  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPECIFIC_HEAT = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEAT_RATIO    = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_RATIO    = 8'd3;

  // what the front decides about a cell before the back works on it
  typedef struct packed {
    logic emit_prev;
    logic update;
    logic prev_dend;
    logic last;
  } item_class_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_SQRT
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CALC,
    B_EMIT1,
    B_EMIT2,
    B_SHIFT
  } back_state_t;

  typedef enum logic [5:0] {
    S_VV, S_RT, S_U1, S_HVV, S_CVT, S_KE, S_U2, S_VR, S_F1, S_PRT, S_EN, S_F2,
    S_GRT, S_SND,
    S_HF0, S_AU0, S_FP0, S_FM0,
    S_HF1, S_AU1, S_FP1, S_FM1,
    S_HF2, S_AU2, S_FP2, S_FM2,
    S_FR, S_FL, S_DF, S_SD, S_UK,
    S_Q1, S_E, S_QQ, S_HQ, S_ES, S_Q2
  } step_t;

endpackage

// ===== src/euler_1d_split_flux_step.sv =====
// Each cell runs in the back sequencer on the shared serial arithmetic
// unit, which multiplies, divides and takes the sound speed root on
// words that are Q16.16 by default. A cell runs 16 multiplies and one
// root for its fluxes, and an updated cell adds 3 multiplies, up to 2
// more and up to 3 divides. A queue of QUEUE_DEPTH words on each side
// lets the input and the result sides stall independently.
// ----------------------------------------------------------------------------
// euler_1d_split_flux_step
// One explicit step of a 1D Euler solver with split fluxes over a stream
// of cells; holds the configuration registers and joins front and back.
// ----------------------------------------------------------------------------
module euler_1d_split_flux_step #(
  parameter int WORD_WIDTH = efs_pkg::WORD_WIDTH,
  parameter int FRAC_BITS  = efs_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [WORD_WIDTH-1:0]  density,
  input  logic signed [WORD_WIDTH-1:0]  velocity,
  input  logic signed [WORD_WIDTH-1:0]  temperature,
  input  logic signed [WORD_WIDTH-1:0]  mass,
  input  logic signed [WORD_WIDTH-1:0]  momentum,
  input  logic signed [WORD_WIDTH-1:0]  energy,
  input  logic                          first_cell,
  input  logic                          last_cell,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [WORD_WIDTH-1:0]  out_density,
  output logic signed [WORD_WIDTH-1:0]  out_velocity,
  output logic signed [WORD_WIDTH-1:0]  out_temperature,
  output logic signed [WORD_WIDTH-1:0]  out_mass,
  output logic signed [WORD_WIDTH-1:0]  out_momentum,
  output logic signed [WORD_WIDTH-1:0]  out_energy,
  output logic                          run_end,
  output logic                          domain_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [efs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int W   = WORD_WIDTH;
  localparam int QW  = 6 * W + $bits(efs_pkg::item_class_t);
  localparam int OW  = 6 * W + 2;
  localparam logic [63:0] MAXV64 = (64'd1 << (W - 1)) - 64'd1;

  logic signed [W-1:0] gas_constant;
  logic signed [W-1:0] specific_heat;
  logic signed [W-1:0] heat_ratio;
  logic signed [W-1:0] step_ratio;

  logic          q_wr;
  logic          q_full;
  logic [QW-1:0] q_wdata;
  logic          q_rd;
  logic [QW-1:0] q_rdata;
  logic          q_empty;
  logic          o_push;
  logic          o_full;
  logic [OW-1:0] o_wdata;
  logic [OW-1:0] o_rdata;

  // clamp a register value into the word range
  function automatic logic [W-1:0] cfg_fit(input logic [efs_pkg::CFG_DATA_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > MAXV64) ? MAXV64[W-1:0] : w[W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gas_constant  <= cfg_fit(efs_pkg::GAS_CONSTANT_RESET);
      specific_heat <= cfg_fit(efs_pkg::SPECIFIC_HEAT_RESET);
      heat_ratio    <= cfg_fit(efs_pkg::HEAT_RATIO_RESET);
      step_ratio    <= cfg_fit(efs_pkg::STEP_RATIO_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        efs_pkg::REG_GAS_CONSTANT:  gas_constant  <= cfg_fit(cfg_data);
        efs_pkg::REG_SPECIFIC_HEAT: specific_heat <= cfg_fit(cfg_data);
        efs_pkg::REG_HEAT_RATIO:    heat_ratio    <= cfg_fit(cfg_data);
        efs_pkg::REG_STEP_RATIO:    step_ratio    <= cfg_fit(cfg_data);
        default: ;
      endcase
    end
  end

  efs_front #(.W(W)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .density     (density),
    .velocity    (velocity),
    .temperature (temperature),
    .mass        (mass),
    .momentum    (momentum),
    .energy      (energy),
    .first_cell  (first_cell),
    .last_cell   (last_cell),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wdata)
  );

  efs_fifo #(.WIDTH(QW), .DEPTH(efs_pkg::QUEUE_DEPTH)) u_cell_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  efs_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .in_empty      (q_empty),
    .in_data       (q_rdata),
    .in_pop        (q_rd),
    .out_full      (o_full),
    .out_push      (o_push),
    .out_data      (o_wdata),
    .gas_constant  (gas_constant),
    .specific_heat (specific_heat),
    .heat_ratio    (heat_ratio),
    .step_ratio    (step_ratio)
  );

  efs_fifo #(.WIDTH(OW), .DEPTH(efs_pkg::QUEUE_DEPTH)) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (o_push),
    .wr_data (o_wdata),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (o_rdata),
    .empty   (empty)
  );

  assign {out_density, out_velocity, out_temperature, out_mass, out_momentum,
          out_energy, run_end, domain_end} = o_rdata;

`ifndef NO_ASSERTIONS
  a_cell_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_full) else $error("cell queue written while full");

  a_result_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    o_push |-> !o_full) else $error("result queue written while full");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty) else $error("result queue not empty after reset");
`endif

endmodule

// ===== src/efs_fifo.sv =====
// ----------------------------------------------------------------------------
// efs_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module efs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

// ===== src/efs_front.sv =====
// ----------------------------------------------------------------------------
// efs_front
// Accepts cells, tracks the domain position and tags each cell with what
// the back has to emit for it.
// ----------------------------------------------------------------------------
module efs_front #(
  parameter int W = efs_pkg::WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [W-1:0]   density,
  input  logic signed [W-1:0]   velocity,
  input  logic signed [W-1:0]   temperature,
  input  logic signed [W-1:0]   mass,
  input  logic signed [W-1:0]   momentum,
  input  logic signed [W-1:0]   energy,
  input  logic                  first_cell,
  input  logic                  last_cell,
  input  logic                  q_full,
  output logic                  q_wr,
  output logic [6*W+$bits(efs_pkg::item_class_t)-1:0] q_data
);

  logic                  have_prev;
  logic                  prev_was_first;
  logic                  start;
  efs_pkg::item_class_t  cls;

  assign full  = q_full;
  assign q_wr  = push && !q_full;
  // a cell with nothing pending opens a domain even without its mark
  assign start = first_cell || !have_prev;

  always_comb begin
    cls.emit_prev = have_prev;
    cls.update    = have_prev && !start && !prev_was_first;
    cls.prev_dend = start;
    cls.last      = last_cell;
  end

  assign q_data = {density, velocity, temperature, mass, momentum, energy, cls};

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev      <= 1'b0;
      prev_was_first <= 1'b0;
    end else if (q_wr) begin
      have_prev      <= !last_cell;
      prev_was_first <= !last_cell && start;
    end
  end

endmodule

// ===== src/efs_alu.sv =====
// ----------------------------------------------------------------------------
// efs_alu
// Shared serial unit: saturating fixed point multiply, divide and square
// root, one bit or one digit per cycle.
// ----------------------------------------------------------------------------
module efs_alu #(
  parameter int W = efs_pkg::WORD_WIDTH,
  parameter int F = efs_pkg::FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  efs_pkg::alu_op_t      op,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic                  done,
  output logic signed [W-1:0]   result
);

  localparam int MW = 2 * W + F;
  localparam int NB = W + F + ((W + F) % 2);
  localparam int HB = NB / 2;
  localparam int RW = ((W > HB) ? W : HB) + 3;
  localparam int CW = $clog2(MW + 1);

  localparam logic [MW-1:0]      LIM_POS = (MW'(1) << (W - 1)) - MW'(1);
  localparam logic [MW-1:0]      LIM_NEG = MW'(1) << (W - 1);
  localparam logic signed [W-1:0] MAXV   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV   = {1'b1, {(W-1){1'b0}}};

  efs_pkg::alu_state_t state;
  efs_pkg::alu_state_t state_next;
  efs_pkg::alu_op_t    op_r;

  logic          neg;
  logic [MW-1:0] acc;
  logic [MW-1:0] mcand;
  logic [W-1:0]  mplier;
  logic [W-1:0]  dvs;
  logic [MW-1:0] num;
  logic [RW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [RW-1:0] r2;
  logic [RW-1:0] r4;
  logic [RW-1:0] trial;
  logic [MW-1:0] m;

  assign mag_a = a[W-1] ? W'(-a) : W'(a);
  assign mag_b = b[W-1] ? W'(-b) : W'(b);
  assign r2    = {rem[RW-2:0], num[W+F-1]};
  assign r4    = {rem[RW-3:0], num[NB-1:NB-2]};
  assign trial = {acc[RW-3:0], 2'b01};

  always_comb begin
    state_next = state;
    case (state)
      efs_pkg::A_IDLE: if (start) state_next = efs_pkg::A_RUN;
      efs_pkg::A_RUN:  if (cnt == '0) state_next = efs_pkg::A_DONE;
      efs_pkg::A_DONE: state_next = efs_pkg::A_IDLE;
      default:         state_next = efs_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    done = (state == efs_pkg::A_DONE);
    m    = (op_r == efs_pkg::ALU_MUL) ? (acc >> F) : acc;
    if (neg) begin
      result = (m > LIM_NEG) ? MINV : W'(-m);
    end else begin
      result = (m > LIM_POS) ? MAXV : W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efs_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == efs_pkg::A_IDLE && start) begin
      op_r   <= op;
      acc    <= '0;
      rem    <= '0;
      mcand  <= MW'(mag_a);
      mplier <= mag_b;
      dvs    <= mag_b;
      case (op)
        efs_pkg::ALU_MUL: begin
          neg <= a[W-1] ^ b[W-1];
          num <= '0;
          cnt <= CW'(W);
        end
        efs_pkg::ALU_DIV: begin
          neg <= a[W-1] ^ b[W-1];
          num <= MW'(mag_a) << F;
          cnt <= CW'(W + F);
        end
        default: begin
          neg <= 1'b0;
          num <= MW'(mag_a) << F;
          // a root of zero or less is zero
          cnt <= (a[W-1] || a == '0) ? '0 : CW'(HB);
        end
      endcase
    end else if (state == efs_pkg::A_RUN && cnt != '0) begin
      cnt <= cnt - CW'(1);
      case (op_r)
        efs_pkg::ALU_MUL: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
        efs_pkg::ALU_DIV: begin
          num <= num << 1;
          if (r2 >= RW'(dvs)) begin
            rem <= r2 - RW'(dvs);
            acc <= {acc[MW-2:0], 1'b1};
          end else begin
            rem <= r2;
            acc <= {acc[MW-2:0], 1'b0};
          end
        end
        default: begin
          num <= num << 2;
          if (r4 >= trial) begin
            rem <= r4 - trial;
            acc <= {acc[MW-2:0], 1'b1};
          end else begin
            rem <= r4;
            acc <= {acc[MW-2:0], 1'b0};
          end
        end
      endcase
    end
  end

endmodule

// ===== src/efs_back.sv =====
// ----------------------------------------------------------------------------
// efs_back
// Sequencer that forms split fluxes, updates the pending cell and emits
// result words, using the shared serial arithmetic unit.
// ----------------------------------------------------------------------------
module efs_back #(
  parameter int W = efs_pkg::WORD_WIDTH,
  parameter int F = efs_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_empty,
  input  logic [6*W+$bits(efs_pkg::item_class_t)-1:0] in_data,
  output logic                in_pop,
  input  logic                out_full,
  output logic                out_push,
  output logic [6*W+1:0]      out_data,
  input  logic signed [W-1:0] gas_constant,
  input  logic signed [W-1:0] specific_heat,
  input  logic signed [W-1:0] heat_ratio,
  input  logic signed [W-1:0] step_ratio
);

  localparam int CLW = $bits(efs_pkg::item_class_t);
  localparam logic signed [W-1:0] HALF = W'(64'd1 << (F - 1));
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  efs_pkg::back_state_t state;
  efs_pkg::back_state_t state_next;
  efs_pkg::step_t       step;
  efs_pkg::step_t       step_next;
  efs_pkg::kind_t       kind;
  efs_pkg::alu_op_t     alu_op;
  efs_pkg::item_class_t cls;

  logic [1:0] kk;
  logic       issued;
  logic       is_arith;
  logic       step_adv;
  logic       calc_end;
  logic       alu_start;
  logic       alu_done;

  logic signed [W-1:0] alu_result;
  logic signed [W-1:0] opa;
  logic signed [W-1:0] opb;
  logic signed [W:0]   sum_w;
  logic signed [W:0]   dif_w;
  logic signed [W-1:0] add_res;
  logic signed [W-1:0] sub_res;
  logic signed [W-1:0] res;

  logic signed [W-1:0] p0, p1, p2, c0, c1, c2;
  logic signed [W-1:0] vv, rt, u1f, u2f, f1, f2, snd, t1, t2, q1, q2;
  logic signed [W-1:0] fp [3];
  logic signed [W-1:0] fm [3];
  logic signed [W-1:0] pp [3];
  logic signed [W-1:0] pm [3];
  logic signed [W-1:0] op [3];
  logic signed [W-1:0] pc [3];
  logic signed [W-1:0] pprim [3];
  logic signed [W-1:0] u [3];

  efs_alu #(.W(W), .F(F)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .op     (alu_op),
    .a      (opa),
    .b      (opb),
    .done   (alu_done),
    .result (alu_result)
  );

  // step operands
  always_comb begin
    kind = efs_pkg::K_MUL;
    opa  = '0;
    opb  = '0;
    case (step)
      efs_pkg::S_VV:  begin opa = p1;        opb = p1;     end
      efs_pkg::S_RT:  begin opa = gas_constant; opb = p2;  end
      efs_pkg::S_U1:  begin opa = p0;        opb = p1;     end
      efs_pkg::S_HVV: begin opa = HALF;      opb = vv;     end
      efs_pkg::S_CVT: begin opa = specific_heat; opb = p2; end
      efs_pkg::S_KE:  begin kind = efs_pkg::K_ADD; opa = t1; opb = t2; end
      efs_pkg::S_U2:  begin opa = p0;        opb = t1;     end
      efs_pkg::S_VR:  begin kind = efs_pkg::K_ADD; opa = vv; opb = rt; end
      efs_pkg::S_F1:  begin opa = p0;        opb = t1;     end
      efs_pkg::S_PRT: begin opa = p0;        opb = rt;     end
      efs_pkg::S_EN:  begin kind = efs_pkg::K_ADD; opa = u2f; opb = t1; end
      efs_pkg::S_F2:  begin opa = p1;        opb = t1;     end
      efs_pkg::S_GRT: begin opa = heat_ratio; opb = rt;    end
      efs_pkg::S_SND: begin kind = efs_pkg::K_SQRT; opa = t1; end
      efs_pkg::S_HF0: begin opa = HALF;      opb = u1f;    end
      efs_pkg::S_AU0: begin opa = snd;       opb = p0;     end
      efs_pkg::S_HF1: begin opa = HALF;      opb = f1;     end
      efs_pkg::S_AU1: begin opa = snd;       opb = u1f;    end
      efs_pkg::S_HF2: begin opa = HALF;      opb = f2;     end
      efs_pkg::S_AU2: begin opa = snd;       opb = u2f;    end
      efs_pkg::S_FP0, efs_pkg::S_FP1, efs_pkg::S_FP2: begin
        kind = efs_pkg::K_ADD; opa = t1; opb = t2;
      end
      efs_pkg::S_FM0, efs_pkg::S_FM1, efs_pkg::S_FM2: begin
        kind = efs_pkg::K_SUB; opa = t1; opb = t2;
      end
      efs_pkg::S_FR:  begin kind = efs_pkg::K_ADD; opa = pp[kk]; opb = fm[kk]; end
      efs_pkg::S_FL:  begin kind = efs_pkg::K_ADD; opa = op[kk]; opb = pm[kk]; end
      efs_pkg::S_DF:  begin kind = efs_pkg::K_SUB; opa = t1; opb = t2; end
      efs_pkg::S_SD:  begin opa = step_ratio; opb = t1;    end
      efs_pkg::S_UK:  begin kind = efs_pkg::K_SUB; opa = pc[kk]; opb = t1; end
      efs_pkg::S_Q1:  begin kind = efs_pkg::K_DIV; opa = u[1]; opb = u[0]; end
      efs_pkg::S_E:   begin kind = efs_pkg::K_DIV; opa = u[2]; opb = u[0]; end
      efs_pkg::S_QQ:  begin opa = q1;        opb = q1;     end
      efs_pkg::S_HQ:  begin opa = HALF;      opb = t1;     end
      efs_pkg::S_ES:  begin kind = efs_pkg::K_SUB; opa = t2; opb = t1; end
      efs_pkg::S_Q2:  begin kind = efs_pkg::K_DIV; opa = t1; opb = specific_heat; end
      default:        begin kind = efs_pkg::K_ADD; end
    endcase
  end

  // saturating add and subtract
  always_comb begin
    sum_w   = {opa[W-1], opa} + {opb[W-1], opb};
    dif_w   = {opa[W-1], opa} - {opb[W-1], opb};
    add_res = (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? MINV : MAXV) : sum_w[W-1:0];
    sub_res = (dif_w[W] != dif_w[W-1]) ? (dif_w[W] ? MINV : MAXV) : dif_w[W-1:0];
    case (kind)
      efs_pkg::K_MUL:  alu_op = efs_pkg::ALU_MUL;
      efs_pkg::K_DIV:  alu_op = efs_pkg::ALU_DIV;
      default:         alu_op = efs_pkg::ALU_SQRT;
    endcase
    is_arith = (kind == efs_pkg::K_ADD) || (kind == efs_pkg::K_SUB);
    res      = (kind == efs_pkg::K_ADD) ? add_res :
               (kind == efs_pkg::K_SUB) ? sub_res : alu_result;
  end

  assign step_adv = (state == efs_pkg::B_CALC) && (is_arith || alu_done);
  assign calc_end = step_adv &&
                    ((step == efs_pkg::S_FM2 && !cls.update) ||
                     (step == efs_pkg::S_UK && kk == 2'd2 && u[0] == '0) ||
                     (step == efs_pkg::S_Q1 && specific_heat == '0) ||
                     (step == efs_pkg::S_Q2));

  // next state and next step
  always_comb begin
    state_next = state;
    case (step)
      efs_pkg::S_FM2: step_next = efs_pkg::S_FR;
      efs_pkg::S_UK:  step_next = (kk == 2'd2) ? efs_pkg::S_Q1 : efs_pkg::S_FR;
      default:        step_next = efs_pkg::step_t'(step + 6'd1);
    endcase
    case (state)
      efs_pkg::B_IDLE:  if (!in_empty) state_next = efs_pkg::B_CALC;
      efs_pkg::B_CALC:  if (calc_end) state_next = efs_pkg::B_EMIT1;
      efs_pkg::B_EMIT1: if (!cls.emit_prev || !out_full) state_next = efs_pkg::B_EMIT2;
      efs_pkg::B_EMIT2: if (!cls.last || !out_full) state_next = efs_pkg::B_SHIFT;
      efs_pkg::B_SHIFT: state_next = efs_pkg::B_IDLE;
      default:          state_next = efs_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_pop    = (state == efs_pkg::B_IDLE) && !in_empty;
    alu_start = (state == efs_pkg::B_CALC) && !is_arith && !issued;
    out_push  = 1'b0;
    out_data  = {p0, p1, p2, c0, c1, c2, 1'b1, 1'b1};
    case (state)
      efs_pkg::B_EMIT1: begin
        out_push = cls.emit_prev && !out_full;
        if (cls.update) begin
          out_data = {u[0], q1, q2, u[0], u[1], u[2], !cls.last, 1'b0};
        end else begin
          out_data = {pprim[0], pprim[1], pprim[2], pc[0], pc[1], pc[2],
                      !cls.last, cls.prev_dend};
        end
      end
      efs_pkg::B_EMIT2: out_push = cls.last && !out_full;
      default:          out_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= efs_pkg::B_IDLE;
      step   <= efs_pkg::S_VV;
      kk     <= '0;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (in_pop) begin
        step <= efs_pkg::S_VV;
      end else if (step_adv) begin
        step <= step_next;
        if (step == efs_pkg::S_FM2) kk <= '0;
        else if (step == efs_pkg::S_UK) kk <= kk + 2'd1;
      end
      if (alu_start) begin
        issued <= 1'b1;
      end else if (alu_done) begin
        issued <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      {p0, p1, p2, c0, c1, c2} <= in_data[6*W+CLW-1:CLW];
      cls <= in_data[CLW-1:0];
      q1  <= '0;
      q2  <= '0;
    end
    if (step_adv) begin
      case (step)
        efs_pkg::S_VV:  vv     <= res;
        efs_pkg::S_RT:  rt     <= res;
        efs_pkg::S_U1:  u1f    <= res;
        efs_pkg::S_U2:  u2f    <= res;
        efs_pkg::S_F1:  f1     <= res;
        efs_pkg::S_F2:  f2     <= res;
        efs_pkg::S_SND: snd    <= res;
        efs_pkg::S_CVT, efs_pkg::S_AU0, efs_pkg::S_AU1, efs_pkg::S_AU2,
        efs_pkg::S_FL, efs_pkg::S_E: t2 <= res;
        efs_pkg::S_FP0: fp[0]  <= res;
        efs_pkg::S_FM0: fm[0]  <= res;
        efs_pkg::S_FP1: fp[1]  <= res;
        efs_pkg::S_FM1: fm[1]  <= res;
        efs_pkg::S_FP2: fp[2]  <= res;
        efs_pkg::S_FM2: fm[2]  <= res;
        efs_pkg::S_UK:  u[kk]  <= res;
        efs_pkg::S_Q1:  q1     <= res;
        efs_pkg::S_Q2:  q2     <= res;
        default:        t1     <= res;
      endcase
    end
    // slide the window once the cell is done
    if (state == efs_pkg::B_SHIFT) begin
      for (int k = 0; k < 3; k++) begin
        op[k] <= pp[k];
        pp[k] <= fp[k];
        pm[k] <= fm[k];
      end
      pc[0]    <= c0;
      pc[1]    <= c1;
      pc[2]    <= c2;
      pprim[0] <= p0;
      pprim[1] <= p1;
      pprim[2] <= p2;
    end
  end

endmodule
